@@ design/mdsg_pkg.sv @@
// shared types and constants for the motor drive safety gate
// no dependencies; imported by mdsg_div, motor_drive_safety_gate_core and tb
`default_nettype none

package mdsg_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_POWER_CAP       = 3'd0;
    localparam logic [2:0] REG_NOMINAL_VOLTAGE = 3'd1;
    localparam logic [2:0] REG_UNDERVOLTAGE_MV = 3'd2;
    localparam logic [2:0] REG_ANGLE_LIMIT     = 3'd3;
    localparam logic [2:0] REG_SPEED_LIMIT     = 3'd4;
    localparam logic [2:0] REG_REARM_BAND      = 3'd5;
    localparam logic [2:0] REG_ARM_DELAY       = 3'd6;

    localparam int CFG_DATA_W = 23;

    // register reset values
    localparam logic [7:0]  RST_POWER_CAP       = 8'd150;
    localparam logic [15:0] RST_NOMINAL_VOLTAGE = 16'd16000;
    localparam logic [14:0] RST_UNDERVOLTAGE_MV = 15'd12000;
    localparam logic [22:0] RST_ANGLE_LIMIT     = 23'd450000;
    localparam logic [14:0] RST_SPEED_LIMIT     = 15'd4000;
    localparam logic [14:0] RST_REARM_BAND      = 15'd20;
    localparam logic [15:0] RST_ARM_DELAY       = 16'd500;

    // direction codes
    localparam logic [1:0] DIR_COAST   = 2'd0;
    localparam logic [1:0] DIR_REVERSE = 2'd1;
    localparam logic [1:0] DIR_FORWARD = 2'd2;

    // tone codes
    localparam logic [1:0] SND_NONE    = 2'd0;
    localparam logic [1:0] SND_DISABLE = 2'd1;
    localparam logic [1:0] SND_ENABLE  = 2'd2;

    // result of the shared scaling divider
    typedef struct packed {
        logic               done;
        logic signed [15:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

@@ design/motor_drive_safety_gate_core.sv @@
// top level of the motor drive safety gate: registers, sequencer, trip logic and drive outputs
// uses mdsg_pkg and the shared scaling divider mdsg_div
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+-------------------------------------------
//  input    | i_in_valid   | o_in_ready   | supply_mv, tilt_angle, speeds, commands
//  result   | o_out_valid  | i_out_ready  | directions, duties, sound_event, latched_off
//  config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// each item scales cap, left and right in turn through the one divider, each with a
// multiply, a range check and, unless the check settles it, 16 restoring steps
// o_in_ready is high only while the sequencer is idle; a finished result waits in the
// output register and a new item may be taken meanwhile
// if the previous result is still untaken at the end of an item the sequencer holds
// reset is synchronous and active low; it restores register defaults and clears latches
`default_nettype none

module motor_drive_safety_gate_core import mdsg_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [14:0]           i_supply_mv,
    input  wire logic signed [23:0]    i_tilt_angle,
    input  wire logic signed [15:0]    i_left_speed,
    input  wire logic signed [15:0]    i_right_speed,
    input  wire logic signed [15:0]    i_left_command,
    input  wire logic signed [15:0]    i_right_command,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [1:0]                 o_left_direction,
    output logic [7:0]                 o_left_duty,
    output logic [1:0]                 o_right_direction,
    output logic [7:0]                 o_right_duty,
    output logic [1:0]                 o_sound_event,
    output logic                       o_latched_off,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        SEL_CAP,
        SEL_LEFT,
        SEL_RIGHT
    } t_sel;

    // configuration
    logic [7:0]  r_power_cap;
    logic [15:0] r_nominal_voltage;
    logic [14:0] r_undervoltage_mv;
    logic [22:0] r_angle_limit;
    logic [14:0] r_speed_limit;
    logic [14:0] r_rearm_band;

    // block state
    logic        r_off_latch;
    logic        r_temp_disabled;
    logic [15:0] r_arm_countdown;

    // sequencer and captured item
    t_state             r_state;
    t_sel               r_sel;
    logic [14:0]        r_supply_mv;
    logic signed [23:0] r_tilt;
    logic signed [15:0] r_lspd;
    logic signed [15:0] r_rspd;
    logic signed [15:0] r_lcmd;
    logic signed [15:0] r_rcmd;
    logic signed [15:0] r_cap;
    logic signed [15:0] r_pl;
    logic signed [15:0] r_pr;

    // result register
    logic       r_out_valid;
    logic [1:0] r_left_dir;
    logic [7:0] r_left_duty;
    logic [1:0] r_right_dir;
    logic [7:0] r_right_duty;
    logic [1:0] r_sound;
    logic       r_latched;

    logic               w_start;
    logic signed [16:0] w_operand;
    t_div_rsp           w_rsp;

    logic        n_off_latch;
    logic [15:0] n_arm_countdown;
    logic        n_temp_disabled;
    logic [1:0]  n_sound;
    logic        w_trip;
    logic        w_in_band;
    logic signed [16:0] w_sum;
    logic signed [24:0] w_alim;
    logic signed [16:0] w_slim;
    logic signed [16:0] w_band;
    logic signed [15:0] w_pl;
    logic signed [15:0] w_pr;
    logic        w_out_free;

    function automatic logic [1:0] drive_dir(input logic signed [15:0] p, input logic off);
        logic [1:0] d;
        if (p == 16'sd0 || off) begin
            d = DIR_COAST;
        end else if (p < 16'sd0) begin
            d = DIR_REVERSE;
        end else begin
            d = DIR_FORWARD;
        end
        return d;
    endfunction

    function automatic logic [7:0] drive_duty(input logic signed [15:0] p,
                                              input logic signed [15:0] cap,
                                              input logic off);
        logic [16:0] mag;
        logic [16:0] lim;
        logic [7:0]  d;
        mag = p[15] ? 17'(-$signed({p[15], p})) : {1'b0, p};
        lim = {1'b0, cap};
        if (lim < mag) begin
            mag = lim;
        end
        if (cap[15]) begin
            mag = 17'd0;
        end
        d = (mag > 17'd255) ? 8'd255 : mag[7:0];
        if (p == 16'sd0 || off) begin
            d = 8'd0;
        end
        return d;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_start     = (r_state == S_START);

    always_comb begin
        case (r_sel)
            SEL_CAP:   w_operand = $signed({9'd0, r_power_cap});
            SEL_LEFT:  w_operand = 17'(r_lcmd);
            SEL_RIGHT: w_operand = 17'(r_rcmd);
            default:   w_operand = 17'sd0;
        endcase
    end

    mdsg_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_operand (w_operand),
        .i_scale   (r_nominal_voltage),
        .i_divisor (r_supply_mv),
        .o_rsp     (w_rsp)
    );

    // end-of-item update
    always_comb begin
        n_off_latch     = r_off_latch || (r_supply_mv < r_undervoltage_mv);
        n_arm_countdown = (r_arm_countdown != 16'd0) ? r_arm_countdown - 16'd1 : 16'd0;
        w_alim  = $signed({2'b00, r_angle_limit});
        w_slim  = $signed({2'b00, r_speed_limit});
        w_band  = $signed({2'b00, r_rearm_band});
        w_sum   = 17'(r_pl) + 17'(r_pr);
        w_trip  = (25'(r_tilt) > w_alim) || (25'(r_tilt) < -w_alim)
               || (17'(r_lspd) > w_slim) || (17'(r_lspd) < -w_slim)
               || (17'(r_rspd) > w_slim) || (17'(r_rspd) < -w_slim);
        w_in_band = (w_sum < w_band) && (w_sum > -w_band);
        n_temp_disabled = r_temp_disabled;
        n_sound         = SND_NONE;
        if (w_trip) begin
            if (!r_temp_disabled) begin
                n_temp_disabled = 1'b1;
                n_sound         = SND_DISABLE;
            end
        end else if (r_temp_disabled && w_in_band && n_arm_countdown == 16'd0) begin
            n_temp_disabled = 1'b0;
            n_sound         = SND_ENABLE;
        end
        w_pl = n_temp_disabled ? 16'sd0 : r_pl;
        w_pr = n_temp_disabled ? 16'sd0 : r_pr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_sel             <= SEL_CAP;
            r_out_valid       <= 1'b0;
            r_off_latch       <= 1'b0;
            r_temp_disabled   <= 1'b0;
            r_arm_countdown   <= RST_ARM_DELAY;
            r_power_cap       <= RST_POWER_CAP;
            r_nominal_voltage <= RST_NOMINAL_VOLTAGE;
            r_undervoltage_mv <= RST_UNDERVOLTAGE_MV;
            r_angle_limit     <= RST_ANGLE_LIMIT;
            r_speed_limit     <= RST_SPEED_LIMIT;
            r_rearm_band      <= RST_REARM_BAND;
        end else begin
            // the finishing state sets valid itself when it frees the register
            if (r_out_valid && i_out_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_POWER_CAP:       r_power_cap       <= i_cfg_data[7:0];
                    REG_NOMINAL_VOLTAGE: r_nominal_voltage <= i_cfg_data[15:0];
                    REG_UNDERVOLTAGE_MV: r_undervoltage_mv <= i_cfg_data[14:0];
                    REG_ANGLE_LIMIT:     r_angle_limit     <= i_cfg_data[22:0];
                    REG_SPEED_LIMIT:     r_speed_limit     <= i_cfg_data[14:0];
                    REG_REARM_BAND:      r_rearm_band      <= i_cfg_data[14:0];
                    REG_ARM_DELAY:       r_arm_countdown   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_supply_mv <= i_supply_mv;
                        r_tilt      <= i_tilt_angle;
                        r_lspd      <= i_left_speed;
                        r_rspd      <= i_right_speed;
                        r_lcmd      <= i_left_command;
                        r_rcmd      <= i_right_command;
                        r_sel       <= SEL_CAP;
                        r_state     <= S_START;
                    end
                end
                S_START: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_rsp.done) begin
                        case (r_sel)
                            SEL_CAP: begin
                                r_cap   <= w_rsp.quot;
                                r_sel   <= SEL_LEFT;
                                r_state <= S_START;
                            end
                            SEL_LEFT: begin
                                r_pl    <= w_rsp.quot;
                                r_sel   <= SEL_RIGHT;
                                r_state <= S_START;
                            end
                            default: begin
                                r_pr    <= w_rsp.quot;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_FIN: begin
                    // wait for the previous result to be taken
                    if (w_out_free) begin
                        r_off_latch     <= n_off_latch;
                        r_arm_countdown <= n_arm_countdown;
                        r_temp_disabled <= n_temp_disabled;
                        r_left_dir      <= drive_dir(w_pl, n_off_latch);
                        r_left_duty     <= drive_duty(w_pl, r_cap, n_off_latch);
                        r_right_dir     <= drive_dir(w_pr, n_off_latch);
                        r_right_duty    <= drive_duty(w_pr, r_cap, n_off_latch);
                        r_sound         <= n_sound;
                        r_latched       <= n_off_latch;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_left_direction  = r_left_dir;
    assign o_left_duty       = r_left_duty;
    assign o_right_direction = r_right_dir;
    assign o_right_duty      = r_right_duty;
    assign o_sound_event     = r_sound;
    assign o_latched_off     = r_latched;

    // the undervoltage latch never clears outside reset
    a_latch_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_off_latch |=> r_off_latch)
        else $error("off latch cleared");

    // a coasting left motor has zero duty
    a_coast_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_left_direction == DIR_COAST) |-> (o_left_duty == 8'd0))
        else $error("left duty nonzero while coasting");

    // a shown tone agrees with the disable flag it came from
    a_enable_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sound_event == SND_ENABLE) |-> !r_temp_disabled)
        else $error("enable tone with drive still disabled");

    a_disable_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sound_event == SND_DISABLE) |-> r_temp_disabled)
        else $error("disable tone with drive enabled");

endmodule

`default_nettype wire

@@ design/mdsg_div.sv @@
// shared scaling unit: operand * scale / divisor, truncated and saturated to 16 bit signed
// one multiply, then a restoring divider one quotient bit per cycle; uses mdsg_pkg
`default_nettype none

module mdsg_div import mdsg_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [16:0] i_operand,
    input  wire logic [15:0]        i_scale,
    input  wire logic [14:0]        i_divisor,
    output t_div_rsp                o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABS,
        S_CHK,
        S_DIV,
        S_FIN
    } t_state;

    t_state             r_state;
    logic signed [33:0] r_prod;
    logic               r_neg;
    logic [31:0]        r_mag;
    logic [14:0]        r_rem;
    logic [15:0]        r_low;
    logic [3:0]         r_cnt;
    logic               r_done;
    logic signed [15:0] r_quot;

    logic [15:0] w_trial;
    logic        w_ge;
    logic [15:0] w_diff;
    logic [33:0] w_abs;

    assign w_abs   = r_prod[33] ? 34'(-r_prod) : 34'(r_prod);
    assign w_trial = {r_rem, r_low[15]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_prod  <= i_operand * $signed({1'b0, i_scale});
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_neg   <= r_prod[33];
                    r_mag   <= w_abs[31:0];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_mag == 32'd0) begin
                        r_quot  <= 16'sd0;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_mag >= {1'b0, i_divisor, 16'h0000}) begin
                        // quotient needs more than 16 bits, also covers a zero divisor
                        r_quot  <= r_neg ? 16'sh8000 : 16'sh7fff;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_rem   <= r_mag[30:16];
                        r_low   <= r_mag[15:0];
                        r_cnt   <= 4'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_ge ? w_diff[14:0] : w_trial[14:0];
                    r_low <= {r_low[14:0], w_ge};
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // r_low now holds the unsigned quotient
                    if (r_neg) begin
                        r_quot <= r_low[15] ? 16'sh8000 : $signed(16'(-r_low));
                    end else begin
                        r_quot <= r_low[15] ? 16'sh7fff : $signed(r_low);
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// testbench for motor_drive_safety_gate_core: directed and random control ticks under
// several register settings, each result checked against an in-bench gate predictor
// depends on mdsg_pkg and the motor_drive_safety_gate_core rtl

module tb import mdsg_pkg::*; ();

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int QUIET_LIMIT = 3000;

    typedef struct packed {
        logic [14:0]        supply_mv;
        logic signed [23:0] tilt_angle;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic signed [15:0] left_command;
        logic signed [15:0] right_command;
    } t_tick;

    typedef struct packed {
        logic [1:0] left_direction;
        logic [7:0] left_duty;
        logic [1:0] right_direction;
        logic [7:0] right_duty;
        logic [1:0] sound_event;
        logic       latched_off;
    } t_drive_result;

    class gate_scoreboard;
        int unsigned power_cap, nominal_mv, undervolt_mv;
        int unsigned angle_limit, speed_limit, rearm_band, arm_delay;
        bit off_latch, temp_disabled;
        int unsigned arm_count;
        t_drive_result expected_q[$];
        int mismatches, results_checked;

        function new();
            power_cap     = RST_POWER_CAP;
            nominal_mv    = RST_NOMINAL_VOLTAGE;
            undervolt_mv  = RST_UNDERVOLTAGE_MV;
            angle_limit   = RST_ANGLE_LIMIT;
            speed_limit   = RST_SPEED_LIMIT;
            rearm_band    = RST_REARM_BAND;
            arm_delay     = RST_ARM_DELAY;
            arm_count     = RST_ARM_DELAY;
            off_latch     = 1'b0;
            temp_disabled = 1'b0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_POWER_CAP:       power_cap = data[7:0];
                REG_NOMINAL_VOLTAGE: nominal_mv = data[15:0];
                REG_UNDERVOLTAGE_MV: undervolt_mv = data[14:0];
                REG_ANGLE_LIMIT:     angle_limit = data[22:0];
                REG_SPEED_LIMIT:     speed_limit = data[14:0];
                REG_REARM_BAND:      rearm_band = data[14:0];
                REG_ARM_DELAY: begin
                    arm_delay = data[15:0];
                    arm_count = data[15:0];
                end
                default: ;
            endcase
        endfunction

        // quotient truncates toward zero; zero supply saturates by the numerator's sign
        function int scale_to_supply(longint num, int unsigned volt);
            longint q;
            if (volt == 0) begin
                if (num > 0) return 32767;
                if (num < 0) return -32768;
                return 0;
            end
            q = num / longint'(volt);
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            return int'(q);
        endfunction

        function logic [9:0] motor_out(int p, int cap);
            int mag;
            if (p == 0 || off_latch) return {DIR_COAST, 8'd0};
            mag = (p < 0) ? -p : p;
            if (cap < mag) mag = cap;
            if (mag < 0) mag = 0;
            if (mag > 255) mag = 255;
            return {(p < 0) ? DIR_REVERSE : DIR_FORWARD, 8'(mag)};
        endfunction

        function void note_tick(t_tick t);
            int cap, pl, pr, sum, tilt, lspd, rspd, alim, slim, band;
            bit trip;
            t_drive_result r;
            cap = scale_to_supply(longint'(power_cap) * longint'(nominal_mv), t.supply_mv);
            pl = scale_to_supply(longint'($signed(t.left_command)) * longint'(nominal_mv),
                                 t.supply_mv);
            pr = scale_to_supply(longint'($signed(t.right_command)) * longint'(nominal_mv),
                                 t.supply_mv);
            if (t.supply_mv < undervolt_mv) off_latch = 1'b1;
            if (arm_count != 0) arm_count--;
            sum  = pl + pr;
            tilt = int'($signed(t.tilt_angle));
            lspd = int'($signed(t.left_speed));
            rspd = int'($signed(t.right_speed));
            alim = int'(angle_limit);
            slim = int'(speed_limit);
            band = int'(rearm_band);
            trip = tilt > alim || tilt < -alim || lspd > slim || lspd < -slim ||
                   rspd > slim || rspd < -slim;
            r.sound_event = SND_NONE;
            if (trip) begin
                if (!temp_disabled) begin
                    temp_disabled = 1'b1;
                    r.sound_event = SND_DISABLE;
                end
            end else if (temp_disabled && sum < band && sum > -band && arm_count == 0) begin
                temp_disabled = 1'b0;
                r.sound_event = SND_ENABLE;
            end
            if (temp_disabled) begin
                pl = 0;
                pr = 0;
            end
            {r.left_direction, r.left_duty}   = motor_out(pl, cap);
            {r.right_direction, r.right_duty} = motor_out(pr, cap);
            r.latched_off = off_latch;
            expected_q.push_back(r);
        endfunction

        function string fmt(t_drive_result r);
            return $sformatf("L %0d/%0d R %0d/%0d tone %0d off %0d", r.left_direction,
                             r.left_duty, r.right_direction, r.right_duty, r.sound_event,
                             r.latched_off);
        endfunction

        function void check_result(t_drive_result got);
            t_drive_result exp;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("result with no tick pending: %s", fmt(got));
                return;
            end
            exp = expected_q.pop_front();
            results_checked++;
            if (got.left_direction !== exp.left_direction || got.left_duty !== exp.left_duty ||
                got.right_direction !== exp.right_direction ||
                got.right_duty !== exp.right_duty || got.sound_event !== exp.sound_event ||
                got.latched_off !== exp.latched_off) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d differs: expected %s, got %s", results_checked,
                             fmt(exp), fmt(got));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [14:0]                i_supply_mv = '0;
    logic signed [23:0]         i_tilt_angle = '0;
    logic signed [15:0]         i_left_speed = '0;
    logic signed [15:0]         i_right_speed = '0;
    logic signed [15:0]         i_left_command = '0;
    logic signed [15:0]         i_right_command = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [1:0]                 o_left_direction;
    logic [7:0]                 o_left_duty;
    logic [1:0]                 o_right_direction;
    logic [7:0]                 o_right_duty;
    logic [1:0]                 o_sound_event;
    logic                       o_latched_off;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [2:0]                 i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;

    gate_scoreboard sb;
    int ticks_sent = 0;
    int settings_loaded = 0;
    int results_taken = 0;
    int quiet_cycles = 0;

    motor_drive_safety_gate_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_supply_mv       (i_supply_mv),
        .i_tilt_angle      (i_tilt_angle),
        .i_left_speed      (i_left_speed),
        .i_right_speed     (i_right_speed),
        .i_left_command    (i_left_command),
        .i_right_command   (i_right_command),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_left_direction  (o_left_direction),
        .o_left_duty       (o_left_duty),
        .o_right_direction (o_right_direction),
        .o_right_duty      (o_right_duty),
        .o_sound_event     (o_sound_event),
        .o_latched_off     (o_latched_off),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_tick('{i_supply_mv, i_tilt_angle, i_left_speed, i_right_speed,
                               i_left_command, i_right_command});
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (o_out_valid && i_out_ready) begin
                sb.check_result('{o_left_direction, o_left_duty, o_right_direction,
                                  o_right_duty, o_sound_event, o_latched_off});
                results_taken++;
            end
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("no transfer for %0d cycles", quiet_cycles);
                $display("FAIL motor_drive_safety_gate_core");
                $finish;
            end
        end
    end

    // result side: random hold-offs, quiet stretches, one long hold to back up the block
    initial begin
        int gap;
        bit long_hold_done;
        long_hold_done = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!long_hold_done && results_taken >= 400) begin
                gap = 600;
                long_hold_done = 1'b1;
            end else if ((results_taken / 60) % 3 == 2) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 17);
            end
            if (gap != 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_tick(t_tick t);
        int gap;
        gap = ((ticks_sent / 50) % 4 == 3) ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_supply_mv     <= t.supply_mv;
        i_tilt_angle    <= t.tilt_angle;
        i_left_speed    <= t.left_speed;
        i_right_speed   <= t.right_speed;
        i_left_command  <= t.left_command;
        i_right_command <= t.right_command;
        i_in_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        ticks_sent++;
    endtask

    // stop offering, wait for every pending result, then let the sequencer go quiet
    task automatic settle(int extra);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // junk above the register width when asked for
    function automatic logic [CFG_DATA_W-1:0] cfg_word(int unsigned v, int w, bit noisy);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'(v);
        if (noisy && w < CFG_DATA_W) d = d | (CFG_DATA_W'($urandom) << w);
        return d;
    endfunction

    task automatic load_settings(input int unsigned cap, nom, uv, alim, slim, band, delay,
                                 input bit noisy);
        write_reg(REG_POWER_CAP,       cfg_word(cap, 8, noisy));
        write_reg(REG_NOMINAL_VOLTAGE, cfg_word(nom, 16, noisy));
        write_reg(REG_UNDERVOLTAGE_MV, cfg_word(uv, 15, noisy));
        write_reg(REG_ANGLE_LIMIT,     cfg_word(alim, 23, noisy));
        write_reg(REG_SPEED_LIMIT,     cfg_word(slim, 15, noisy));
        write_reg(REG_REARM_BAND,      cfg_word(band, 15, noisy));
        write_reg(REG_UNUSED,          CFG_DATA_W'($urandom));
        write_reg(REG_ARM_DELAY,       cfg_word(delay, 16, noisy));
        i_cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    function automatic int unsigned pick(int unsigned mn, mx, lo, hi);
        case ($urandom_range(0, 9))
            0: return mn;
            1: return mx;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    function automatic t_tick mk(int s, int tilt, int ls, int rs, int lc, int rc);
        t_tick t;
        t.supply_mv     = 15'(s);
        t.tilt_angle    = 24'(tilt);
        t.left_speed    = 16'(ls);
        t.right_speed   = 16'(rs);
        t.left_command  = 16'(lc);
        t.right_command = 16'(rc);
        return t;
    endfunction

    function automatic int near_zero(int unsigned lim);
        return int'($urandom_range(0, 2 * lim)) - int'(lim);
    endfunction

    // mostly plausible ticks inside the limits with the odd trip, plus raw noise
    function automatic t_tick random_tick();
        t_tick t;
        t = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 99) < 12) return t;
        case ($urandom_range(0, 9))
            0:       t.supply_mv = '0;
            1, 2:    ;
            default: t.supply_mv = 15'($urandom_range(8000, 32767));
        endcase
        t.tilt_angle  = 24'(near_zero(sb.angle_limit));
        t.left_speed  = 16'(near_zero(sb.speed_limit));
        t.right_speed = 16'(near_zero(sb.speed_limit));
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 2))
                0:       t.tilt_angle = 24'($urandom);
                1:       t.left_speed = 16'($urandom);
                default: t.right_speed = 16'($urandom);
            endcase
        end
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                t.left_command  = '0;
                t.right_command = '0;
            end
            3, 4: begin
                t.left_command  = 16'(int'($urandom_range(0, 6)) - 3);
                t.right_command = 16'(int'($urandom_range(0, 6)) - 3);
            end
            5, 6, 7: begin
                t.left_command  = 16'(int'($urandom_range(0, 800)) - 400);
                t.right_command = 16'(int'($urandom_range(0, 800)) - 400);
            end
            default: ;
        endcase
        return t;
    endfunction

    task automatic run_random(int n);
        repeat (n) send_tick(random_tick());
    endtask

    initial begin
        int p;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset settings: arm countdown still long, supply kept clear of the latch
        send_tick(mk(16000, 0, 0, 0, 100, -100));
        send_tick(mk(16000, 0, 0, 0, 32767, -32768));
        send_tick(mk(16000, 450000, 4000, -4000, 0, 0));
        send_tick(mk(16000, 450001, 0, 0, 50, 50));
        send_tick(mk(16000, -450001, 0, 0, 0, 0));
        send_tick(mk(16000, 0, -4001, 0, 0, 0));
        send_tick(mk(12000, 0, 0, 0, 5, 5));
        send_tick(mk(32767, 0, 0, 4001, 0, 0));
        settle(80);

        // short arm delay: re-arm at and inside the band, zero and low supply saturation
        load_settings(150, 16000, 0, 450000, 4000, 20, 2, 1'b0);
        send_tick(mk(16000, 0, 0, 0, 0, 0));
        send_tick(mk(16000, 0, 0, 0, 0, 0));
        send_tick(mk(16000, -8388608, 0, 0, 0, 0));
        send_tick(mk(16000, 0, 0, 0, 10, 10));
        send_tick(mk(16000, 0, 0, 0, 10, 9));
        send_tick(mk(16000, 0, 0, 0, -10, -10));
        send_tick(mk(0, 0, 0, 0, 1, -1));
        send_tick(mk(0, 0, 0, 0, 0, 0));
        send_tick(mk(1, 0, 0, 0, 32767, -32768));
        send_tick(mk(32767, 0, 0, 0, 1, -3));
        send_tick(mk(16000, 8388607, 0, 0, 0, 0));
        send_tick(mk(32767, -1, 32767, -32768, 32767, 32767));
        settle(80);

        load_settings(0, 0, 0, 0, 0, 0, 0, 1'b0);
        run_random(60);
        settle(80);
        load_settings(255, 65535, 0, 8388607, 32767, 32767, 65535, 1'b1);
        run_random(100);

        for (p = 0; p < 8; p++) begin
            settle(80);
            load_settings(pick(0, 255, 0, 255), pick(0, 65535, 8000, 32000), 0,
                          pick(0, 8388607, 50000, 2000000), pick(0, 32767, 500, 10000),
                          pick(0, 32767, 4, 300), pick(0, 65535, 0, 30), 1'b1);
            if (p == 3) begin
                run_random(70);
                settle(0);
                run_random(70);
            end else begin
                run_random(140);
            end
        end

        // undervoltage at its highest threshold: the off latch sets and stays set
        settle(80);
        load_settings(150, 16000, 32767, 450000, 4000, 20, 0, 1'b0);
        run_random(100);
        settle(80);

        $display("%0d ticks under %0d register settings, %0d results compared, %0d mismatches",
                 ticks_sent, settings_loaded, sb.results_checked, sb.mismatches);
        $display("covered trips, re-arming, zero and low supply saturation and the off latch");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS motor_drive_safety_gate_core");
        end else begin
            if (sb.pending() != 0) $display("%0d ticks never produced a result", sb.pending());
            $display("FAIL motor_drive_safety_gate_core");
        end
        $finish;
    end

endmodule
